// ----- design/hex_record_page_writer_assert.svh -----
// assertion macros used by the hex record page writer checker
// no dependencies; included by hrpw_checker.sv, which holds concurrent assertions
`ifndef HEX_RECORD_PAGE_WRITER_ASSERT_SVH
`define HEX_RECORD_PAGE_WRITER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HRPW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define HRPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/hrpw_pkg.sv -----
// shared types and constants for the hex record page writer
// no dependencies; imported by every module of the block
package hrpw_pkg;

  // default page size in bytes
  localparam int PAGE_BYTES_DEF = 64;

  // depth of the command queue between parser and framer
  localparam int CMD_DEPTH = 4;

  // character codes
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] ALPHA_GAP  = 8'd7;

  // frame header bytes
  localparam logic [7:0] SYNC_BYTE0 = 8'hAA;
  localparam logic [7:0] SYNC_BYTE1 = 8'h55;
  localparam logic [7:0] WRITE_CMD  = 8'h50;

  // character positions within a line
  localparam logic [9:0] POS_MAX      = 10'd1023;
  localparam logic [9:0] POS_LEN_LAST = 10'd2;
  localparam logic [9:0] POS_ADDR_1ST = 10'd3;
  localparam logic [9:0] POS_ADDR_LST = 10'd6;
  localparam logic [9:0] POS_TYPE_LST = 10'd8;

  // one data byte handed from parser to framer
  typedef struct packed {
    logic [7:0]  data;
    logic        hdr;
    logic [15:0] addr;
    logic        last;
  } hrpw_cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } hrpw_q_status_t;

endpackage

// ----- design/hrpw_char_if.sv -----
// character input channel: valid/ready handshake carrying one ASCII code
// no dependencies
interface hrpw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ----- design/hrpw_spi_if.sv -----
// serial byte output channel: valid/ready handshake with frame markers
// no dependencies
interface hrpw_spi_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       frame_start;
  logic       frame_end;
  logic       last_of_run;

  modport source (output valid, output spi_byte, output frame_start,
                  output frame_end, output last_of_run, input ready);
  modport sink   (input valid, input spi_byte, input frame_start,
                  input frame_end, input last_of_run, output ready);
endinterface

// ----- design/hex_record_page_writer.sv -----
// top level of the hex record page writer: parser, command queue, frame builder
// depends on hrpw_pkg, hrpw_char_if, hrpw_spi_if, hrpw_front, hrpw_cmd_fifo, hrpw_back
//
//   channel   dir  payload                                          items
//   char_ch   in   char_code[7:0]                                   one per line char
//   spi_ch    out  spi_byte[7:0] frame_start frame_end last_of_run  0, 1 or 6 per char
//
// one character is taken per cycle while the 4-entry command queue has room
// each data byte makes one output byte, six when it opens a frame; the frame
// builder draining one byte per cycle while spi_ch.ready is high sets the sustained output rate
// spi_ch.ready held low stalls the builder, the queue fills, then char_ch.ready drops
// synchronous reset, char_ch.ready is low while rst is high; no clearing pass
module hex_record_page_writer #(
  parameter int PAGE_BYTES = hrpw_pkg::PAGE_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  hrpw_char_if.sink  char_ch,
  hrpw_spi_if.source spi_ch
);
  import hrpw_pkg::*;

  logic           push;
  logic           pop;
  hrpw_cmd_t      push_cmd;
  hrpw_cmd_t      pop_cmd;
  hrpw_q_status_t q_status;

  // character parser
  hrpw_front #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .char_ch  (char_ch),
    .push     (push),
    .push_cmd (push_cmd),
    .q_status (q_status)
  );

  // command queue
  hrpw_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  // frame builder
  hrpw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (pop_cmd),
    .q_status (q_status),
    .pop      (pop),
    .spi_ch   (spi_ch)
  );

endmodule

// ----- design/hrpw_front.sv -----
// line parser: decodes hex characters, tracks page position, issues data commands
// depends on hrpw_pkg and hrpw_char_if
module hrpw_front #(
  parameter int PAGE_BYTES = hrpw_pkg::PAGE_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  hrpw_char_if.sink               char_ch,
  output logic                    push,
  output hrpw_pkg::hrpw_cmd_t     push_cmd,
  input  hrpw_pkg::hrpw_q_status_t q_status
);
  import hrpw_pkg::*;

  localparam int OFS_W = $clog2(PAGE_BYTES);
  localparam logic [OFS_W:0]   PAGE_W   = (OFS_W+1)'(PAGE_BYTES);
  localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(PAGE_BYTES - 1);
  localparam int WRAP_REM_I = (PAGE_BYTES - (65536 % PAGE_BYTES)) % PAGE_BYTES;
  localparam logic [OFS_W-1:0] WRAP_REM = OFS_W'(WRAP_REM_I);

  logic [9:0]       char_position;
  logic [7:0]       record_length;
  logic [15:0]      chunk_address;
  logic [OFS_W-1:0] chunk_rem;
  logic [3:0]       high_nibble;
  logic [7:0]       data_index;
  logic [OFS_W-1:0] page_offset;
  logic             frame_open;

  logic             accept;
  logic [7:0]       code;
  logic [7:0]       dec_v;
  logic [3:0]       nib;
  logic [OFS_W-1:0] rem_in;
  logic [OFS_W-1:0] rem_new;
  logic             take_data;
  logic             page_end;
  logic             rec_end;
  logic [15:0]      page_base;
  logic [16:0]      next_sum;

  // remainder of (r * 16 + n) by the page size, one bit at a time
  function automatic logic [OFS_W-1:0] rem_step(input logic [OFS_W-1:0] r,
                                                input logic [3:0] n);
    logic [OFS_W:0] t;
    t = {1'b0, r};
    for (int i = 3; i >= 0; i--) begin
      t = {t[OFS_W-1:0], n[i]};
      if (t >= PAGE_W) begin
        t = t - PAGE_W;
      end
    end
    return t[OFS_W-1:0];
  endfunction

  assign accept = char_ch.valid && char_ch.ready;
  assign char_ch.ready = !rst && !q_status.full;
  assign code = char_ch.char_code;

  // nibble decode, lower case and junk fall out of the same arithmetic
  always_comb begin
    dec_v = code - CHAR_ZERO;
    if (code >= CHAR_UPPER) begin
      dec_v = dec_v - ALPHA_GAP;
    end
    nib = dec_v[3:0];
  end

  // running remainder of the address restarts at its first digit
  assign rem_in  = (char_position == POS_ADDR_1ST) ? '0 : chunk_rem;
  assign rem_new = rem_step(rem_in, nib);

  // data byte on the low-nibble character while the record still has bytes
  assign take_data = (code != CHAR_LF) && (char_position > POS_TYPE_LST) &&
                     !char_position[0] && (data_index < record_length);
  assign page_end  = (page_offset == OFS_LAST);
  assign rec_end   = ((data_index + 8'd1) == record_length);

  // start of next page, wrapping at 16 bits
  assign page_base = chunk_address - 16'(chunk_rem);
  assign next_sum  = {1'b0, page_base} + 17'(PAGE_BYTES);

  assign push          = accept && take_data;
  assign push_cmd.data = {high_nibble, nib};
  assign push_cmd.hdr  = !frame_open;
  assign push_cmd.addr = chunk_address;
  assign push_cmd.last = page_end || rec_end;

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      record_length <= '0;
      chunk_address <= '0;
      chunk_rem     <= '0;
      high_nibble   <= '0;
      data_index    <= '0;
      page_offset   <= '0;
      frame_open    <= 1'b0;
    end else if (accept) begin
      if (code == CHAR_LF) begin
        char_position <= '0;
        data_index    <= '0;
        frame_open    <= 1'b0;
      end else begin
        if (char_position < POS_MAX) begin
          char_position <= char_position + 10'd1;
        end
        if (char_position == '0) begin
          // start code, skipped
        end else if (char_position <= POS_LEN_LAST) begin
          record_length <= {record_length[3:0], nib};
        end else if (char_position <= POS_ADDR_LST) begin
          chunk_address <= {chunk_address[11:0], nib};
          chunk_rem     <= rem_new;
          if (char_position == POS_ADDR_LST) begin
            page_offset <= rem_new;
          end
        end else if (char_position <= POS_TYPE_LST) begin
          // record type, ignored
        end else if (char_position[0]) begin
          high_nibble <= nib;
        end else if (take_data) begin
          data_index <= data_index + 8'd1;
          frame_open <= !(page_end || rec_end);
          if (page_end) begin
            page_offset   <= '0;
            chunk_address <= next_sum[15:0];
            chunk_rem     <= next_sum[16] ? WRAP_REM : '0;
          end else begin
            page_offset <= page_offset + OFS_W'(1);
          end
        end
      end
    end
  end

endmodule

// ----- design/hrpw_cmd_fifo.sv -----
// short command queue between the parser and the frame builder
// depends on hrpw_pkg
module hrpw_cmd_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  hrpw_pkg::hrpw_cmd_t      push_cmd,
  input  logic                     pop,
  output hrpw_pkg::hrpw_cmd_t      pop_cmd,
  output hrpw_pkg::hrpw_q_status_t q_status
);
  import hrpw_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);

  hrpw_cmd_t        entries [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign q_status.full  = (count == (PTR_W+1)'(CMD_DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_cmd        = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/hrpw_back.sv -----
// frame builder: expands each queued data byte into header and data transfers
// depends on hrpw_pkg and hrpw_spi_if
module hrpw_back (
  input  logic                     clk,
  input  logic                     rst,
  input  hrpw_pkg::hrpw_cmd_t      cmd,
  input  hrpw_pkg::hrpw_q_status_t q_status,
  output logic                     pop,
  hrpw_spi_if.source               spi_ch
);
  import hrpw_pkg::*;

  typedef enum logic [2:0] {
    ST_SYNC0,
    ST_SYNC1,
    ST_CMD,
    ST_ADDR_HI,
    ST_ADDR_LO,
    ST_DATA
  } step_t;

  step_t step;
  step_t cur;
  step_t step_next;
  logic  load;

  // commands without a header go straight to their data byte
  assign cur  = cmd.hdr ? step : ST_DATA;
  assign load = !q_status.empty && (!spi_ch.valid || spi_ch.ready);
  assign pop  = load && (cur == ST_DATA);

  always_comb begin
    unique case (step)
      ST_SYNC0:   step_next = ST_SYNC1;
      ST_SYNC1:   step_next = ST_CMD;
      ST_CMD:     step_next = ST_ADDR_HI;
      ST_ADDR_HI: step_next = ST_ADDR_LO;
      default:    step_next = ST_DATA;
    endcase
  end

  // step counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_SYNC0;
      spi_ch.valid <= 1'b0;
    end else begin
      if (load) begin
        spi_ch.valid       <= 1'b1;
        spi_ch.frame_start <= (cur == ST_SYNC0);
        spi_ch.frame_end   <= (cur == ST_DATA) && cmd.last;
        spi_ch.last_of_run <= (cur == ST_DATA);
        unique case (cur)
          ST_SYNC0:   spi_ch.spi_byte <= SYNC_BYTE0;
          ST_SYNC1:   spi_ch.spi_byte <= SYNC_BYTE1;
          ST_CMD:     spi_ch.spi_byte <= WRITE_CMD;
          ST_ADDR_HI: spi_ch.spi_byte <= cmd.addr[15:8];
          ST_ADDR_LO: spi_ch.spi_byte <= cmd.addr[7:0];
          default:    spi_ch.spi_byte <= cmd.data;
        endcase
        step <= (cur == ST_DATA) ? ST_SYNC0 : step_next;
      end else if (spi_ch.ready) begin
        spi_ch.valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/hrpw_checker.sv -----
// port-level checks on the hex record page writer, bound to the top level
// depends on hex_record_page_writer_assert.svh and hrpw_pkg
`include "hex_record_page_writer_assert.svh"

module hrpw_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] spi_byte,
  input logic       frame_start,
  input logic       frame_end,
  input logic       last_of_run
);
  import hrpw_pkg::*;

  // a frame opens with the first sync byte and never ends a run
  `HRPW_ASSERT_NOW(a_start_sync, out_valid && frame_start, (spi_byte == SYNC_BYTE0) && !last_of_run && !frame_end, "frame start without sync byte")

  // only a data byte can close a frame
  `HRPW_ASSERT_NOW(a_end_on_data, out_valid && frame_end, last_of_run && !frame_start, "frame end on a header byte")

  // a stalled transfer holds its byte
  `HRPW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(spi_byte) && $stable(frame_end), "output changed while stalled")

  // nothing is offered right after reset
  `HRPW_ASSERT_NOW(a_reset_quiet, $past(rst), !out_valid, "output valid right after reset")

endmodule

bind hex_record_page_writer hrpw_checker u_hrpw_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (spi_ch.valid),
  .out_ready   (spi_ch.ready),
  .spi_byte    (spi_ch.spi_byte),
  .frame_start (spi_ch.frame_start),
  .frame_end   (spi_ch.frame_end),
  .last_of_run (spi_ch.last_of_run)
);
